### src/rdac_pkg.sv
`timescale 1ns / 1ps

package rdac_pkg;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } rdac_state_t;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } rdac_op_t;

    typedef enum logic [1:0] {
        PORT_MASK   = 2'd0,
        PORT_RINDEX = 2'd1,
        PORT_WINDEX = 2'd2,
        PORT_DATA   = 2'd3
    } rdac_port_t;

    localparam logic [7:0] ID_BYTE    = 8'h70;
    localparam logic [7:0] MASK_RESET = 8'hff;
    localparam logic [2:0] UNLOCK_ID  = 3'd4;
    localparam logic [2:0] UNLOCK_CMD = 3'd5;

    localparam int BPP_W = 6;
    localparam int DIV_W = 3;

endpackage

### src/rdac_ram.sv
`timescale 1ns / 1ps

module rdac_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/rdac_cmd_dec.sv
`timescale 1ns / 1ps

module rdac_cmd_dec (
    input  logic [7:0]                cmd,
    output logic [rdac_pkg::BPP_W-1:0] bits_per_pixel,
    output logic [rdac_pkg::DIV_W-1:0] clock_divider_x2
);
    import rdac_pkg::*;

    logic [3:0] mode;

    assign mode = cmd[7:4];

    always_comb begin
        unique case (mode)
            4'h2, 4'h3, 4'h8, 4'ha: bits_per_pixel = BPP_W'(15);
            4'h4, 4'h9, 4'he:       bits_per_pixel = BPP_W'(24);
            4'h5, 4'h6, 4'hc:       bits_per_pixel = BPP_W'(16);
            4'h7, 4'hd:             bits_per_pixel = BPP_W'(32);
            default:                bits_per_pixel = BPP_W'(8);
        endcase
    end

    always_comb begin
        unique case (mode)
            4'h1:                                clock_divider_x2 = DIV_W'(1);
            4'h9:                                clock_divider_x2 = DIV_W'(3);
            4'h2, 4'h6, 4'h7, 4'h8, 4'ha, 4'hc:  clock_divider_x2 = DIV_W'(4);
            4'h4, 4'he:                          clock_divider_x2 = DIV_W'(6);
            default:                             clock_divider_x2 = DIV_W'(2);
        endcase
    end

endmodule

### src/ramdac_command_and_pll_registers.sv
`timescale 1ns / 1ps
// result: the accept moves the FSM to the execute state, which registers the result beat
// access: the table memory is read in the accept cycle and written back in the following
//   cycle; one access in flight, and a new one is taken only in idle with the output free
// reset: synchronous active-low aresetn clears the unlock, mode, index and phase
//   registers and all table valid bits at once, so the table reads as zero; no clearing pass

module ramdac_command_and_pll_registers #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // write_data
    input  logic [2:0]  s_tuser,   // opcode, port_offset[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // read_data[7:0], forward_to_vga, bits_per_pixel[5:0],
                                   // clock_divider_x2[2:0], mode_changed, zero pad
    output logic [0:0]  m_tuser    // read_handled
);
    import rdac_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // index modulo depth by restoring reduction; quotient of an 8-bit index fits 4 bits for a depth of 16 or more
    function automatic logic [AW-1:0] table_addr(input logic [7:0] idx);
        logic [11:0] rem;
        rem = {4'b0, idx};
        for (int k = 3; k >= 0; k--) begin
            if (rem >= 12'(TABLE_DEPTH << k)) begin
                rem = rem - 12'(TABLE_DEPTH << k);
            end
        end
        return rem[AW-1:0];
    endfunction

    rdac_state_t state_reg, state_next;

    logic [2:0] unlock_count_reg, unlock_count_next;
    logic       ext_en_reg, ext_en_next;
    logic [7:0] command_reg, command_next;
    logic [7:0] read_index_reg, read_index_next;
    logic [7:0] write_index_reg, write_index_next;
    logic       phase_reg, phase_next;

    logic [TABLE_DEPTH-1:0] valid_reg;

    // captured access
    rdac_op_t   op_reg;
    rdac_port_t port_reg;
    logic [7:0] wdata_reg;
    logic [AW-1:0] addr_reg;

    // result register
    logic        m_tvalid_reg, m_tvalid_next;
    logic [7:0]  rdata_reg, rdata_next;
    logic        handled_reg, handled_next;
    logic        forward_reg;
    logic [BPP_W-1:0] bpp_reg;
    logic [DIV_W-1:0] div_reg;
    logic        changed_reg, changed_next;

    logic          accept;
    logic [AW-1:0] acc_addr;
    logic [15:0]   ram_q;
    logic [15:0]   word_old;
    logic [15:0]   word_new;
    logic          ram_we;
    logic [2:0]    cnt_inc;
    logic [BPP_W-1:0] bpp_dec;
    logic [DIV_W-1:0] div_dec;

    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign acc_addr = table_addr((rdac_op_t'(s_tuser[0]) == OP_WRITE) ?
                                 write_index_reg : read_index_reg);

    rdac_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (word_new),
        .re    (accept),
        .raddr (acc_addr),
        .rdata (ram_q)
    );

    // entries never written since reset read as zero
    assign word_old = valid_reg[addr_reg] ? ram_q : 16'h0000;
    assign cnt_inc  = (unlock_count_reg < UNLOCK_CMD) ? unlock_count_reg + 3'd1
                                                       : unlock_count_reg;

    always_comb begin
        state_next        = state_reg;
        unlock_count_next = unlock_count_reg;
        ext_en_next       = ext_en_reg;
        command_next      = command_reg;
        read_index_next   = read_index_reg;
        write_index_next  = write_index_reg;
        phase_next        = phase_reg;
        rdata_next        = 8'h00;
        handled_next      = 1'b0;
        changed_next      = 1'b0;
        word_new          = word_old;
        ram_we            = 1'b0;
        m_tvalid_next     = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next    = ST_IDLE;
                m_tvalid_next = 1'b1;
                if (op_reg == OP_WRITE) begin
                    if (port_reg == PORT_MASK) begin
                        if (wdata_reg == MASK_RESET) begin
                            ext_en_next       = 1'b0;
                            unlock_count_next = 3'd0;
                        end else if (unlock_count_reg == UNLOCK_ID) begin
                            command_next = wdata_reg;
                            changed_next = 1'b1;
                        end
                    end else begin
                        unlock_count_next = 3'd0;
                        if (ext_en_reg) begin
                            unique case (port_reg)
                                PORT_RINDEX: read_index_next  = wdata_reg;
                                PORT_WINDEX: write_index_next = wdata_reg;
                                default: begin
                                    ram_we     = 1'b1;
                                    phase_next = !phase_reg;
                                    if (!phase_reg) begin
                                        word_new = {word_old[15:8], wdata_reg};
                                    end else begin
                                        word_new         = {wdata_reg, word_old[7:0]};
                                        write_index_next = write_index_reg + 8'd1;
                                    end
                                end
                            endcase
                        end
                    end
                end else begin
                    if (port_reg == PORT_MASK) begin
                        phase_next        = 1'b0;
                        unlock_count_next = cnt_inc;
                        if (cnt_inc == UNLOCK_ID) begin
                            rdata_next   = ID_BYTE;
                            handled_next = 1'b1;
                            ext_en_next  = 1'b1;
                        end else if (cnt_inc == UNLOCK_CMD) begin
                            rdata_next        = command_reg;
                            handled_next      = 1'b1;
                            unlock_count_next = 3'd0;
                        end
                    end else begin
                        unlock_count_next = 3'd0;
                        if (ext_en_reg) begin
                            handled_next = 1'b1;
                            unique case (port_reg)
                                PORT_RINDEX: rdata_next = read_index_reg;
                                PORT_WINDEX: rdata_next = write_index_reg;
                                default: begin
                                    rdata_next = phase_reg ? word_old[15:8] : word_old[7:0];
                                    phase_next = !phase_reg;
                                    if (phase_reg) begin
                                        read_index_next = read_index_reg + 8'd1;
                                    end
                                end
                            endcase
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    rdac_cmd_dec u_dec (
        .cmd              (command_next),
        .bits_per_pixel   (bpp_dec),
        .clock_divider_x2 (div_dec)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            unlock_count_reg <= 3'd0;
            ext_en_reg       <= 1'b0;
            command_reg      <= 8'h00;
            read_index_reg   <= 8'h00;
            write_index_reg  <= 8'h00;
            phase_reg        <= 1'b0;
            valid_reg        <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            unlock_count_reg <= unlock_count_next;
            ext_en_reg       <= ext_en_next;
            command_reg      <= command_next;
            read_index_reg   <= read_index_next;
            write_index_reg  <= write_index_next;
            phase_reg        <= phase_next;
            m_tvalid_reg     <= m_tvalid_next;
            if (ram_we) begin
                valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= rdac_op_t'(s_tuser[0]);
            port_reg  <= rdac_port_t'(s_tuser[2:1]);
            wdata_reg <= s_tdata;
            addr_reg  <= acc_addr;
        end
        if (state_reg == ST_EXEC) begin
            rdata_reg   <= rdata_next;
            handled_reg <= handled_next;
            forward_reg <= (op_reg == OP_WRITE) || !handled_next;
            bpp_reg     <= bpp_dec;
            div_reg     <= div_dec;
            changed_reg <= changed_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = handled_reg;
    assign m_tdata  = {5'b0, changed_reg, div_reg, bpp_reg, forward_reg, rdata_reg};

    a_exec_gives_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) |=> m_tvalid_reg)
        else $error("result beat missing after execute cycle");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_EXEC) && !s_tready)
        else $error("second access accepted while one is in flight");

    a_unlock_range: assert property (@(posedge aclk) disable iff (!aresetn)
        unlock_count_reg <= UNLOCK_ID)
        else $error("unlock count out of range");

    a_load_not_handled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && changed_reg) |-> (!handled_reg && forward_reg))
        else $error("command load flagged as handled read");

    a_handled_not_fwd: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && handled_reg) |-> !forward_reg)
        else $error("handled read also forwarded");

endmodule
